FILE: src/bounded_unique_value_set_assert.svh
// Assertion macros used by the bounded unique value set RTL.
`ifndef BOUNDED_UNIQUE_VALUE_SET_ASSERT_SVH
`define BOUNDED_UNIQUE_VALUE_SET_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BUVS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BUVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/buvs_pkg.sv
// Shared types and constants of the bounded unique value set.
package buvs_pkg;

  // Store geometry.
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned AddrW      = $clog2(MaxEntries);
  localparam int unsigned CountW     = $clog2(MaxEntries + 1);
  localparam int unsigned ValueW     = 32;
  localparam int unsigned IndexW     = 4;
  localparam int unsigned OpW        = 2;
  localparam int unsigned StatusW    = 2;

  // Request kinds.
  typedef enum logic [OpW-1:0] {
    OpAdd  = 2'd0,
    OpTest = 2'd1,
    OpRead = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic execute;
  } cmd_t;

endpackage

FILE: src/buvs_datapath.sv
// Datapath: request registers, value store, parallel compare and result registers.
module buvs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  buvs_pkg::cmd_t               cmd_i,
  input  logic [buvs_pkg::OpW-1:0]     operation_i,
  input  logic signed [buvs_pkg::ValueW-1:0] value_i,
  input  logic [buvs_pkg::IndexW-1:0]  index_i,
  output logic                         found_o,
  output logic signed [buvs_pkg::ValueW-1:0] read_value_o,
  output logic [buvs_pkg::CountW-1:0]  entry_count_o,
  output logic [buvs_pkg::StatusW-1:0] status_o
);

  logic [buvs_pkg::OpW-1:0]     op_q;
  logic [buvs_pkg::ValueW-1:0]  value_q;
  logic [buvs_pkg::IndexW-1:0]  idx_q;
  logic [buvs_pkg::ValueW-1:0]  entries_q [buvs_pkg::MaxEntries];
  logic [buvs_pkg::CountW-1:0]  count_q, count_d;
  logic [buvs_pkg::MaxEntries-1:0] match;
  logic                         hit;
  logic                         full;
  logic                         in_range;
  logic                         store_en;
  logic                         found_d, found_q;
  logic [buvs_pkg::ValueW-1:0]  rd_d, rd_q;
  buvs_pkg::status_e            status_d, status_q;

  // Capture the request beat when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q    <= operation_i;
      value_q <= value_i;
      idx_q   <= index_i;
    end
  end

  // Compare the value against every occupied entry at once.
  always_comb begin
    for (int i = 0; i < buvs_pkg::MaxEntries; i++) begin
      match[i] = (entries_q[i] == value_q) && (32'(i) < 32'(count_q));
    end
  end

  assign hit      = |match;
  assign full     = (count_q == buvs_pkg::CountW'(buvs_pkg::MaxEntries));
  assign in_range = (32'(idx_q) < 32'(count_q));

  // Decode the request into a result and a store update.
  always_comb begin
    found_d  = 1'b0;
    rd_d     = '0;
    status_d = buvs_pkg::StOk;
    store_en = 1'b0;
    case (buvs_pkg::op_e'(op_q))
      buvs_pkg::OpAdd: begin
        if (hit) begin
          found_d = 1'b1;
        end else if (full) begin
          status_d = buvs_pkg::StFull;
        end else begin
          store_en = 1'b1;
        end
      end
      buvs_pkg::OpTest: begin
        found_d = hit;
      end
      buvs_pkg::OpRead: begin
        if (in_range) begin
          rd_d = entries_q[buvs_pkg::AddrW'(idx_q)];
        end else begin
          status_d = buvs_pkg::StRange;
        end
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  assign count_d = store_en ? count_q + 1'b1 : count_q;

  // Append a new value at the next free slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && store_en) begin
      entries_q[count_q[buvs_pkg::AddrW-1:0]] <= value_q;
    end
  end

  // The entry count is control state and clears on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Result register, held until the beat leaves.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      found_q  <= found_d;
      rd_q     <= rd_d;
      status_q <= status_d;
    end
  end

  assign found_o       = found_q;
  assign read_value_o  = rd_q;
  assign entry_count_o = count_q;
  assign status_o      = status_q;

endmodule

FILE: src/buvs_ctrl.sv
// Controller: sequences accept, execute and result delivery for one request at a time.
module buvs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output buvs_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StHold
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_take;
  logic   accept;

  // A new beat may enter when idle, or while the held result leaves.
  assign can_take   = (state_q == StIdle) || ((state_q == StHold) && !out_stall_i);
  assign in_stall_o = !can_take;
  assign accept     = in_valid_i && can_take;

  assign cmd_o.load_req = accept;
  assign cmd_o.execute  = (state_q == StExec);
  assign out_valid_o    = out_valid_q;

  // State and registered result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q     <= StHold;
          out_valid_q <= 1'b1;
        end
        StHold: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= accept ? StExec : StIdle;
          end
        end
        default: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: src/bounded_unique_value_set.sv
// Top level of the bounded unique value set.
//
// Holds up to 16 distinct signed 32-bit values in insertion order. The input
// channel (in_valid_i / in_stall_o) carries one request beat: an operation
// (add, membership test, read at index), a value and an index. The output
// channel (out_valid_o / out_stall_i) returns one result beat per request with
// found, read_value, entry_count and status.
// The request register is loaded on accept, the compare and store update run
// in the execute cycle, and the result register is loaded at its end.
// A new request is taken in the same cycle the pending result beat leaves, as
// the controller handles a single request at a time.
// Reset (rst_ni low, asynchronous) empties the set and drops any pending beat.
// While the receiver stalls, the result beat holds steady and in_stall_o stays
// high, so no further request enters.
module bounded_unique_value_set (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [buvs_pkg::OpW-1:0]           operation_i,
  input  logic signed [buvs_pkg::ValueW-1:0] value_i,
  input  logic [buvs_pkg::IndexW-1:0]        index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic signed [buvs_pkg::ValueW-1:0] read_value_o,
  output logic [buvs_pkg::CountW-1:0]        entry_count_o,
  output logic [buvs_pkg::StatusW-1:0]       status_o
);

  `include "bounded_unique_value_set_assert.svh"

  buvs_pkg::cmd_t cmd;
  logic           in_beat;
  logic           at_cap;
  logic           over_cap;
  logic           full_err;

  // Sequencing.
  buvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Storage and compute.
  buvs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  // Terms used by the checks below.
  assign in_beat  = in_valid_i && !in_stall_o;
  assign at_cap   = (entry_count_o == buvs_pkg::CountW'(buvs_pkg::MaxEntries));
  assign over_cap = (entry_count_o > buvs_pkg::CountW'(buvs_pkg::MaxEntries));
  assign full_err = out_valid_o && (status_o == buvs_pkg::StFull);

  // An accepted beat is executed before any result is shown for it.
  `BUVS_ASSERT_NEXT(a_accept_then_exec, in_beat, cmd.execute && !out_valid_o, "beat not executed")
  // A full error is only reported when the store is at capacity.
  `BUVS_ASSERT_IMPL(a_full_at_cap, full_err, at_cap, "full status below capacity")
  // A hit never comes with an error status.
  `BUVS_ASSERT_IMPL(a_found_ok, out_valid_o && found_o, status_o == buvs_pkg::StOk, "found with error")
  // While a result is shown, the count never exceeds the capacity.
  `BUVS_ASSERT_IMPL(a_count_cap, out_valid_o, !over_cap, "count above capacity")

endmodule
